>>> rtl/gnnf_pkg.sv
// Shared constants and types for the nearest-neighbor radar/camera fusion block.
// No dependencies; used by the top level.
package gnnf_pkg;

    // Table geometry
    localparam int MAX_RADAR = 64;
    localparam int IDX_W     = (MAX_RADAR > 1) ? $clog2(MAX_RADAR) : 1;
    localparam int CNT_W     = $clog2(MAX_RADAR + 1);

    // Field widths fixed by the interface
    localparam int COORD_W  = 16;
    localparam int ID_W     = 16;
    localparam int CFG_W    = 16;
    localparam int RIDX_W   = 6;
    localparam int OP_W     = 2;
    localparam int CFG_IDX_W = 2;

    // Arithmetic widths
    localparam int DIFF_W = COORD_W + 1;          // signed difference
    localparam int SQ_W   = 2 * COORD_W;          // one square
    localparam int D2_W   = SQ_W + 1;             // sum of two squares
    localparam int PROD_W = CFG_W + 1 + COORD_W;  // weight times coordinate
    localparam int SUM_W  = PROD_W + 2;           // two products plus rounding
    localparam int FRAC_W = 15;                   // Q1.15 weights

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_BEGIN_FRAME = 2'd0,
        OP_LOAD_RADAR  = 2'd1,
        OP_CAMERA      = 2'd2,
        OP_RESERVED    = 2'd3
    } opcode_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GATE       = 2'd0,
        CFG_CAM_WEIGHT = 2'd1,
        CFG_RAD_WEIGHT = 2'd2,
        CFG_UNUSED     = 2'd3
    } cfg_index_t;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] GATE_RESET       = 16'd1600;
    localparam logic [CFG_W-1:0] CAM_WEIGHT_RESET = 16'd16384;
    localparam logic [CFG_W-1:0] RAD_WEIGHT_RESET = 16'd16384;

endpackage

>>> rtl/gnnf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module gnnf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/greedy_nearest_neighbor_fusion.sv
// Top level of the greedy nearest-neighbor radar/camera fusion block.
// Depends on gnnf_pkg and gnnf_ram (radar position table).

// A frame opens with a begin-frame beat (opcode 0), which empties the radar table.
// Each load beat (opcode 1) appends a radar position to the 64-entry table with
// its used mark clear; loads past a full table are dropped. A camera-track beat
// (opcode 2) reads the table one entry per cycle through its single read port,
// compares squared distances against the squared gate, marks the nearest unused
// entry as used and returns one result beat with the weighted, saturated fused
// position. After a camera beat is taken, in_stall stays high through the scan
// and the fusion steps, and longer while the previous result is still held; the
// result is registered at the edge that drops in_stall. A finished result waits
// in the output register, so the next beat is taken while it is held.
module greedy_nearest_neighbor_fusion (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [gnnf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gnnf_pkg::CFG_W-1:0]          cfg_data,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [gnnf_pkg::OP_W-1:0]           opcode,
    input  logic [gnnf_pkg::ID_W-1:0]           track_id,
    input  logic signed [gnnf_pkg::COORD_W-1:0] pos_x,
    input  logic signed [gnnf_pkg::COORD_W-1:0] pos_y,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [gnnf_pkg::ID_W-1:0]           out_track_id,
    output logic signed [gnnf_pkg::COORD_W-1:0] camera_x,
    output logic signed [gnnf_pkg::COORD_W-1:0] camera_y,
    output logic                                has_radar,
    output logic [gnnf_pkg::RIDX_W-1:0]         radar_index,
    output logic signed [gnnf_pkg::COORD_W-1:0] radar_x,
    output logic signed [gnnf_pkg::COORD_W-1:0] radar_y,
    output logic signed [gnnf_pkg::COORD_W-1:0] fused_x,
    output logic signed [gnnf_pkg::COORD_W-1:0] fused_y
);

    localparam int CW  = gnnf_pkg::COORD_W;
    localparam int IW  = gnnf_pkg::IDX_W;
    localparam int NW  = gnnf_pkg::CNT_W;
    localparam int FRAC_W_L = gnnf_pkg::FRAC_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FUSE_MUL,
        ST_FUSE_SUM
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic [gnnf_pkg::CFG_W-1:0] gate_reg;
    logic [gnnf_pkg::CFG_W-1:0] cam_weight_reg;
    logic [gnnf_pkg::CFG_W-1:0] rad_weight_reg;

    // Frame state
    logic [NW-1:0]                 count_reg;

    // Current camera track
    logic [gnnf_pkg::ID_W-1:0] id_reg;
    logic signed [CW-1:0]      cam_x_reg;
    logic signed [CW-1:0]      cam_y_reg;
    logic [gnnf_pkg::SQ_W-1:0] gate2_reg;

    // Scan pipeline
    logic [NW-1:0]          issue_idx_reg;
    logic                   rd_valid_reg;
    logic [IW-1:0]          rd_idx_reg;
    logic                   s1_valid_reg;
    logic                   s1_skip_reg;
    logic [IW-1:0]          s1_idx_reg;
    logic [CW-1:0]          s1_ax_reg;
    logic [CW-1:0]          s1_ay_reg;
    logic signed [CW-1:0]   s1_rx_reg;
    logic signed [CW-1:0]   s1_ry_reg;
    logic                   s2_valid_reg;
    logic                   s2_skip_reg;
    logic [IW-1:0]          s2_idx_reg;
    logic [gnnf_pkg::SQ_W-1:0] s2_sqx_reg;
    logic [gnnf_pkg::SQ_W-1:0] s2_sqy_reg;
    logic signed [CW-1:0]   s2_rx_reg;
    logic signed [CW-1:0]   s2_ry_reg;

    // Best candidate so far
    logic                      found_reg;
    logic [gnnf_pkg::D2_W-1:0] best_reg;
    logic [IW-1:0]             best_idx_reg;
    logic signed [CW-1:0]      best_rx_reg;
    logic signed [CW-1:0]      best_ry_reg;

    // Fusion products
    logic signed [gnnf_pkg::PROD_W-1:0] pcx_reg;
    logic signed [gnnf_pkg::PROD_W-1:0] prx_reg;
    logic signed [gnnf_pkg::PROD_W-1:0] pcy_reg;
    logic signed [gnnf_pkg::PROD_W-1:0] pry_reg;

    // Output register
    logic                      out_valid_reg;
    logic [gnnf_pkg::ID_W-1:0] out_id_reg;
    logic signed [CW-1:0]      out_cam_x_reg;
    logic signed [CW-1:0]      out_cam_y_reg;
    logic                      out_has_reg;
    logic [gnnf_pkg::RIDX_W-1:0] out_ridx_reg;
    logic signed [CW-1:0]      out_rx_reg;
    logic signed [CW-1:0]      out_ry_reg;
    logic signed [CW-1:0]      out_fx_reg;
    logic signed [CW-1:0]      out_fy_reg;

    // Handshake
    logic in_accept;
    logic out_free;
    logic table_full;

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign table_full = (count_reg >= NW'(gnnf_pkg::MAX_RADAR));

    // Radar table: used mark on top, then x, then y in the lower half
    logic              ram_we;
    logic              mark_we;
    logic [IW-1:0]     ram_waddr;
    logic [2*CW:0]     ram_wdata;
    logic              ram_re;
    logic [IW-1:0]     ram_raddr;
    logic [2*CW:0]     ram_rdata;
    logic              issue_done;

    assign mark_we    = (state_reg == ST_FUSE_MUL) && found_reg;
    assign ram_we     = (in_accept && (opcode == gnnf_pkg::OP_LOAD_RADAR) && !table_full)
                        || mark_we;
    assign ram_waddr  = mark_we ? best_idx_reg : count_reg[IW-1:0];
    assign ram_wdata  = mark_we ? {1'b1, best_rx_reg, best_ry_reg} : {1'b0, pos_x, pos_y};
    assign issue_done = (issue_idx_reg >= count_reg);
    assign ram_re     = (state_reg == ST_SCAN) && !issue_done;
    assign ram_raddr  = issue_idx_reg[IW-1:0];

    gnnf_ram #(
        .WIDTH (2 * CW + 1),
        .DEPTH (gnnf_pkg::MAX_RADAR)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Stage 1: absolute differences and the skip test
    logic                                 rd_used;
    logic signed [CW-1:0]                 rd_rx;
    logic signed [CW-1:0]                 rd_ry;
    logic signed [gnnf_pkg::DIFF_W-1:0]   dx;
    logic signed [gnnf_pkg::DIFF_W-1:0]   dy;
    logic [gnnf_pkg::DIFF_W-1:0]          ax;
    logic [gnnf_pkg::DIFF_W-1:0]          ay;
    logic                                 rd_skip;

    assign rd_used = ram_rdata[2*CW];
    assign rd_rx   = ram_rdata[2*CW-1:CW];
    assign rd_ry   = ram_rdata[CW-1:0];
    assign dx      = gnnf_pkg::DIFF_W'(cam_x_reg) - gnnf_pkg::DIFF_W'(rd_rx);
    assign dy      = gnnf_pkg::DIFF_W'(cam_y_reg) - gnnf_pkg::DIFF_W'(rd_ry);
    assign ax      = dx[gnnf_pkg::DIFF_W-1] ? -dx : dx;
    assign ay      = dy[gnnf_pkg::DIFF_W-1] ? -dy : dy;
    assign rd_skip = rd_used || ax[gnnf_pkg::DIFF_W-1] || ay[gnnf_pkg::DIFF_W-1];

    // Stage 3: distance and best-so-far test
    logic [gnnf_pkg::D2_W-1:0] d2;
    logic                      take;

    assign d2   = gnnf_pkg::D2_W'(s2_sqx_reg) + gnnf_pkg::D2_W'(s2_sqy_reg);
    assign take = s2_valid_reg && !s2_skip_reg
                  && (d2 < gnnf_pkg::D2_W'(gate2_reg))
                  && (!found_reg || (d2 < best_reg));

    // Fusion: round half up, floor shift, saturate
    function automatic logic signed [CW-1:0] fuse_sat(
        input logic signed [gnnf_pkg::PROD_W-1:0] pc,
        input logic signed [gnnf_pkg::PROD_W-1:0] pr
    );
        logic signed [gnnf_pkg::SUM_W-1:0]          s;
        logic signed [gnnf_pkg::SUM_W-FRAC_W_L-1:0] q;
        s = gnnf_pkg::SUM_W'(pc) + gnnf_pkg::SUM_W'(pr)
            + gnnf_pkg::SUM_W'(1 << (gnnf_pkg::FRAC_W - 1));
        q = s[gnnf_pkg::SUM_W-1:gnnf_pkg::FRAC_W];
        if (q > (gnnf_pkg::SUM_W-FRAC_W_L)'(signed'((1 << (CW - 1)) - 1)))
        begin
            fuse_sat = {1'b0, {(CW-1){1'b1}}};
        end
        else if (q < -(gnnf_pkg::SUM_W-FRAC_W_L)'(signed'(1 << (CW - 1))))
        begin
            fuse_sat = {1'b1, {(CW-1){1'b0}}};
        end
        else
        begin
            fuse_sat = q[CW-1:0];
        end
    endfunction

    logic signed [CW-1:0] fx_next;
    logic signed [CW-1:0] fy_next;

    assign fx_next = found_reg ? fuse_sat(pcx_reg, prx_reg) : cam_x_reg;
    assign fy_next = found_reg ? fuse_sat(pcy_reg, pry_reg) : cam_y_reg;

    // Configuration writes; indexes past the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_reg       <= gnnf_pkg::GATE_RESET;
            cam_weight_reg <= gnnf_pkg::CAM_WEIGHT_RESET;
            rad_weight_reg <= gnnf_pkg::RAD_WEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gnnf_pkg::CFG_GATE:       gate_reg       <= cfg_data;
                gnnf_pkg::CFG_CAM_WEIGHT: cam_weight_reg <= cfg_data;
                gnnf_pkg::CFG_RAD_WEIGHT: rad_weight_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // Control state, frame state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            issue_idx_reg <= '0;
            rd_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_id_reg    <= '0;
            out_cam_x_reg <= '0;
            out_cam_y_reg <= '0;
            out_has_reg   <= 1'b0;
            out_ridx_reg  <= '0;
            out_rx_reg    <= '0;
            out_ry_reg    <= '0;
            out_fx_reg    <= '0;
            out_fy_reg    <= '0;
        end
        else
        begin
            // drop the held result once taken, unless a new one replaces it
            if (out_valid_reg && !out_stall && (state_reg != ST_FUSE_SUM))
            begin
                out_valid_reg <= 1'b0;
            end

            // advance the scan pipeline valids
            rd_valid_reg <= ram_re;
            s1_valid_reg <= rd_valid_reg;
            s2_valid_reg <= s1_valid_reg;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        unique case (gnnf_pkg::opcode_t'(opcode))
                            gnnf_pkg::OP_BEGIN_FRAME:
                            begin
                                count_reg <= '0;
                            end
                            gnnf_pkg::OP_LOAD_RADAR:
                            begin
                                if (!table_full)
                                begin
                                    count_reg <= count_reg + NW'(1);
                                end
                            end
                            gnnf_pkg::OP_CAMERA:
                            begin
                                issue_idx_reg <= '0;
                                found_reg     <= 1'b0;
                                state_reg     <= ST_SCAN;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (ram_re)
                    begin
                        issue_idx_reg <= issue_idx_reg + NW'(1);
                    end
                    if (take)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (issue_done && !rd_valid_reg && !s1_valid_reg && !s2_valid_reg)
                    begin
                        state_reg <= ST_FUSE_MUL;
                    end
                end
                ST_FUSE_MUL:
                begin
                    // the used mark is written back to the table here
                    state_reg <= ST_FUSE_SUM;
                end
                ST_FUSE_SUM:
                begin
                    // hold until the output register is free
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_id_reg    <= id_reg;
                        out_cam_x_reg <= cam_x_reg;
                        out_cam_y_reg <= cam_y_reg;
                        out_has_reg   <= found_reg;
                        out_ridx_reg  <= found_reg ? gnnf_pkg::RIDX_W'(best_idx_reg) : '0;
                        out_rx_reg    <= found_reg ? best_rx_reg : '0;
                        out_ry_reg    <= found_reg ? best_ry_reg : '0;
                        out_fx_reg    <= fx_next;
                        out_fy_reg    <= fy_next;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers of the scan and fusion
    always_ff @(posedge clk)
    begin
        // capture the camera track
        if (in_accept && (opcode == gnnf_pkg::OP_CAMERA))
        begin
            id_reg    <= track_id;
            cam_x_reg <= pos_x;
            cam_y_reg <= pos_y;
            gate2_reg <= gnnf_pkg::SQ_W'(gate_reg) * gnnf_pkg::SQ_W'(gate_reg);
        end

        rd_idx_reg <= issue_idx_reg[IW-1:0];

        // stage 1
        s1_skip_reg <= rd_skip;
        s1_idx_reg  <= rd_idx_reg;
        s1_ax_reg   <= ax[CW-1:0];
        s1_ay_reg   <= ay[CW-1:0];
        s1_rx_reg   <= rd_rx;
        s1_ry_reg   <= rd_ry;

        // stage 2
        s2_skip_reg <= s1_skip_reg;
        s2_idx_reg  <= s1_idx_reg;
        s2_sqx_reg  <= gnnf_pkg::SQ_W'(s1_ax_reg) * gnnf_pkg::SQ_W'(s1_ax_reg);
        s2_sqy_reg  <= gnnf_pkg::SQ_W'(s1_ay_reg) * gnnf_pkg::SQ_W'(s1_ay_reg);
        s2_rx_reg   <= s1_rx_reg;
        s2_ry_reg   <= s1_ry_reg;

        // stage 3: keep the nearest candidate, lowest index on a tie
        if (take)
        begin
            best_reg     <= d2;
            best_idx_reg <= s2_idx_reg;
            best_rx_reg  <= s2_rx_reg;
            best_ry_reg  <= s2_ry_reg;
        end

        // weight products
        if (state_reg == ST_FUSE_MUL)
        begin
            pcx_reg <= gnnf_pkg::PROD_W'($signed({1'b0, cam_weight_reg}))
                       * gnnf_pkg::PROD_W'(cam_x_reg);
            prx_reg <= gnnf_pkg::PROD_W'($signed({1'b0, rad_weight_reg}))
                       * gnnf_pkg::PROD_W'(best_rx_reg);
            pcy_reg <= gnnf_pkg::PROD_W'($signed({1'b0, cam_weight_reg}))
                       * gnnf_pkg::PROD_W'(cam_y_reg);
            pry_reg <= gnnf_pkg::PROD_W'($signed({1'b0, rad_weight_reg}))
                       * gnnf_pkg::PROD_W'(best_ry_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_track_id = out_id_reg;
    assign camera_x     = out_cam_x_reg;
    assign camera_y     = out_cam_y_reg;
    assign has_radar    = out_has_reg;
    assign radar_index  = out_ridx_reg;
    assign radar_x      = out_rx_reg;
    assign radar_y      = out_ry_reg;
    assign fused_x      = out_fx_reg;
    assign fused_y      = out_fy_reg;

    // A result only appears after the fusion step
    a_out_from_fuse: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FUSE_SUM))
        else $error("result raised outside fusion step");

    // An unmatched result carries the camera position and zero radar fields
    a_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_has_reg) |-> (out_ridx_reg == '0) && (out_rx_reg == '0)
            && (out_ry_reg == '0) && (out_fx_reg == out_cam_x_reg)
            && (out_fy_reg == out_cam_y_reg))
        else $error("unmatched result with radar data");

    // The table fill never passes its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NW'(gnnf_pkg::MAX_RADAR))
        else $error("radar count past table depth");

    // Scan pipeline only carries beats while scanning
    a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_valid_reg || s1_valid_reg || s2_valid_reg) |-> (state_reg == ST_SCAN))
        else $error("scan pipeline busy outside scan");

endmodule

>>> tb/greedy_nearest_neighbor_fusion_tb.sv
// Self-checking testbench for greedy_nearest_neighbor_fusion: queued frames of radar loads
// and camera tracks feed the input channel, and a scoreboard predicts every fused track.
// Depends on gnnf_pkg and the RTL top level greedy_nearest_neighbor_fusion.
module greedy_nearest_neighbor_fusion_tb;

    localparam int COORD_W        = gnnf_pkg::COORD_W;
    localparam int ID_W           = gnnf_pkg::ID_W;
    localparam int CFG_W          = gnnf_pkg::CFG_W;
    localparam int CFG_IDX_W      = gnnf_pkg::CFG_IDX_W;
    localparam int OP_W           = gnnf_pkg::OP_W;
    localparam int RIDX_W         = gnnf_pkg::RIDX_W;
    localparam int FRAC_W         = gnnf_pkg::FRAC_W;
    localparam int MAX_RADAR      = gnnf_pkg::MAX_RADAR;
    localparam int HOLD_CYCLES    = 600;   // long receiver hold-off
    localparam int SETTLE_CYCLES  = 100;   // covers one full-table scan and then some
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with work outstanding and no beat
    localparam int MAX_WAIT       = 19;
    localparam int MAX_PRINTS     = 200;
    localparam int COORD_MAX      = (1 << (COORD_W - 1)) - 1;
    localparam int COORD_MIN      = -(1 << (COORD_W - 1));

    typedef struct packed {
        gnnf_pkg::opcode_t         op;
        logic [ID_W-1:0]           id;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } beat_t;

    typedef struct packed {
        logic [ID_W-1:0]           track;
        logic signed [COORD_W-1:0] cam_x;
        logic signed [COORD_W-1:0] cam_y;
        logic                      matched;
        logic [RIDX_W-1:0]         ridx;
        logic signed [COORD_W-1:0] rad_x;
        logic signed [COORD_W-1:0] rad_y;
        logic signed [COORD_W-1:0] fus_x;
        logic signed [COORD_W-1:0] fus_y;
    } fusion_t;

    // DUT connections
    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = gnnf_pkg::CFG_GATE;
    logic [CFG_W-1:0]          cfg_data  = '0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    logic [OP_W-1:0]           opcode    = gnnf_pkg::OP_BEGIN_FRAME;
    logic [ID_W-1:0]           track_id  = '0;
    logic signed [COORD_W-1:0] pos_x     = '0;
    logic signed [COORD_W-1:0] pos_y     = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [ID_W-1:0]           out_track_id;
    logic signed [COORD_W-1:0] camera_x;
    logic signed [COORD_W-1:0] camera_y;
    logic                      has_radar;
    logic [RIDX_W-1:0]         radar_index;
    logic signed [COORD_W-1:0] radar_x;
    logic signed [COORD_W-1:0] radar_y;
    logic signed [COORD_W-1:0] fused_x;
    logic signed [COORD_W-1:0] fused_y;

    // Predicted block state
    logic [CFG_W-1:0]          gate_reg   = gnnf_pkg::GATE_RESET;
    logic [CFG_W-1:0]          cam_weight = gnnf_pkg::CAM_WEIGHT_RESET;
    logic [CFG_W-1:0]          rad_weight = gnnf_pkg::RAD_WEIGHT_RESET;
    logic signed [COORD_W-1:0] radar_x_mem [MAX_RADAR];
    logic signed [COORD_W-1:0] radar_y_mem [MAX_RADAR];
    bit                        used_mark   [MAX_RADAR];
    int                        radar_count = 0;

    // Traffic bookkeeping
    beat_t   beats_pending[$];
    fusion_t expected_fusions[$];
    beat_t   tx_beat;
    int      beats_queued  = 0;
    int      beats_taken   = 0;
    int      phase_items   = 0;
    int      tx_gap        = 0;
    int      rx_wait       = 0;
    int      hold_left     = 0;
    int      idle_cycles   = 0;
    int      error_count   = 0;
    bit      tx_idle       = 1'b1;
    bit      rx_idle       = 1'b1;
    bit      hold_arm      = 1'b0;
    bit      hold_taken    = 1'b0;

    greedy_nearest_neighbor_fusion u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .track_id     (track_id),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_track_id (out_track_id),
        .camera_x     (camera_x),
        .camera_y     (camera_y),
        .has_radar    (has_radar),
        .radar_index  (radar_index),
        .radar_x      (radar_x),
        .radar_y      (radar_y),
        .fused_x      (fused_x),
        .fused_y      (fused_y)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Weighted blend of one coordinate, round half up, saturated to the coordinate range
    function automatic logic signed [COORD_W-1:0] fuse_coord(
        input logic signed [COORD_W-1:0] cam,
        input logic signed [COORD_W-1:0] rad
    );
        longint cw, rw, c, r, s;
        cw = longint'(cam_weight);
        rw = longint'(rad_weight);
        c  = longint'(cam);
        r  = longint'(rad);
        s  = (cw * c + rw * r + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W;
        if (s > COORD_MAX)
            s = COORD_MAX;
        else if (s < COORD_MIN)
            s = COORD_MIN;
        return s[COORD_W-1:0];
    endfunction

    // Advance the predicted table by one accepted beat; a camera beat queues its fusion
    function automatic void apply_beat(input beat_t b);
        longint  gate_sq, best, dx, dy, d2;
        int      pick, i;
        bit      found;
        fusion_t f;
        case (b.op)
            gnnf_pkg::OP_BEGIN_FRAME:
            begin
                radar_count = 0;
                for (i = 0; i < MAX_RADAR; i++)
                    used_mark[i] = 1'b0;
            end
            gnnf_pkg::OP_LOAD_RADAR:
            begin
                // drop loads past a full table
                if (radar_count < MAX_RADAR)
                begin
                    radar_x_mem[radar_count] = b.x;
                    radar_y_mem[radar_count] = b.y;
                    used_mark[radar_count]   = 1'b0;
                    radar_count++;
                end
            end
            gnnf_pkg::OP_CAMERA:
            begin
                gate_sq = longint'(gate_reg) * longint'(gate_reg);
                best    = 0;
                pick    = 0;
                found   = 1'b0;
                // nearest unused entry strictly inside the gate, lowest index on a tie
                for (i = 0; i < radar_count; i++)
                begin
                    if (!used_mark[i])
                    begin
                        dx = longint'(b.x) - longint'(radar_x_mem[i]);
                        dy = longint'(b.y) - longint'(radar_y_mem[i]);
                        d2 = dx * dx + dy * dy;
                        if (d2 < gate_sq && (!found || d2 < best))
                        begin
                            best  = d2;
                            pick  = i;
                            found = 1'b1;
                        end
                    end
                end
                f.track   = b.id;
                f.cam_x   = b.x;
                f.cam_y   = b.y;
                f.matched = found;
                if (found)
                begin
                    used_mark[pick] = 1'b1;
                    f.ridx  = pick[RIDX_W-1:0];
                    f.rad_x = radar_x_mem[pick];
                    f.rad_y = radar_y_mem[pick];
                    f.fus_x = fuse_coord(b.x, radar_x_mem[pick]);
                    f.fus_y = fuse_coord(b.y, radar_y_mem[pick]);
                end
                else
                begin
                    f.ridx  = '0;
                    f.rad_x = '0;
                    f.rad_y = '0;
                    f.fus_x = b.x;
                    f.fus_y = b.y;
                end
                expected_fusions = {expected_fusions, f};
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < MAX_PRINTS)
            $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    task automatic check_field(
        input string           name,
        input logic [15:0]     got,
        input logic [15:0]     want,
        input logic [ID_W-1:0] track
    );
        if (got !== want)
            report_mismatch($sformatf("track %h %s got %h want %h", track, name, got, want));
    endtask

    // Compare one result beat against the oldest predicted fusion
    task automatic check_result();
        fusion_t e;
        if (expected_fusions.size() == 0)
            report_mismatch($sformatf("result for track %h with nothing pending", out_track_id));
        else
        begin
            e = expected_fusions.pop_front();
            check_field("out_track_id", out_track_id, e.track, e.track);
            check_field("camera_x", camera_x, e.cam_x, e.track);
            check_field("camera_y", camera_y, e.cam_y, e.track);
            check_field("has_radar", {15'd0, has_radar}, {15'd0, e.matched}, e.track);
            check_field("radar_index", {10'd0, radar_index}, {10'd0, e.ridx}, e.track);
            check_field("radar_x", radar_x, e.rad_x, e.track);
            check_field("radar_y", radar_y, e.rad_y, e.track);
            check_field("fused_x", fused_x, e.fus_x, e.track);
            check_field("fused_y", fused_y, e.fus_y, e.track);
        end
    endtask

    // Input driver: present queued beats, hold a stalled beat, wait a drawn gap if tx_idle
    always @(posedge clk or negedge rst_n)
    begin : drive_beats
        int    gap;
        beat_t nb;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            tx_gap      <= 0;
            beats_taken <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                apply_beat(tx_beat);
                beats_taken <= beats_taken + 1;
            end
            if (!in_valid || !in_stall)
            begin
                gap = tx_gap;
                if (in_valid)
                    gap = tx_idle ? $urandom_range(0, MAX_WAIT) : 0;
                if (gap == 0 && beats_pending.size() > 0)
                begin
                    nb = beats_pending.pop_front();
                    tx_beat  <= nb;
                    opcode   <= nb.op;
                    track_id <= nb.id;
                    pos_x    <= nb.x;
                    pos_y    <= nb.y;
                    in_valid <= 1'b1;
                end
                else
                begin
                    if (gap > 0)
                        gap--;
                    in_valid <= 1'b0;
                end
                tx_gap <= gap;
            end
        end
    end

    // Output monitor: check each result, stall a drawn count if rx_idle or a long hold
    always @(posedge clk or negedge rst_n)
    begin : watch_results
        int w, h;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            rx_wait    <= 0;
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end
        else
        begin
            w = rx_wait;
            h = hold_left;
            if (out_valid && !out_stall)
            begin
                check_result();
                w = rx_idle ? $urandom_range(0, MAX_WAIT) : 0;
            end
            else if (out_valid && w > 0)
                w--;
            if (hold_arm && !hold_taken)
            begin
                h = HOLD_CYCLES;
                hold_taken <= 1'b1;
            end
            else if (h > 0)
                h--;
            rx_wait   <= w;
            hold_left <= h;
            out_stall <= (w > 0) || (h > 0);
        end
    end

    // Watchdog: end the run when work is outstanding and no beat moves for too long
    always @(posedge clk)
    begin
        if (rst_n && (beats_taken != beats_queued || expected_fusions.size() != 0)
            && !(in_valid && !in_stall) && !(out_valid && !out_stall))
            idle_cycles <= idle_cycles + 1;
        else
            idle_cycles <= 0;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send(
        input gnnf_pkg::opcode_t op,
        input logic [15:0]       id,
        input logic [15:0]       x,
        input logic [15:0]       y
    );
        beat_t b;
        b.op = op;
        b.id = id;
        b.x  = x;
        b.y  = y;
        beats_pending = {beats_pending, b};
        beats_queued++;
        if (op != gnnf_pkg::OP_RESERVED)
            phase_items++;
    endtask

    task automatic write_register(
        input gnnf_pkg::cfg_index_t idx,
        input logic [CFG_W-1:0]     value
    );
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            gnnf_pkg::CFG_GATE:       gate_reg   = value;
            gnnf_pkg::CFG_CAM_WEIGHT: cam_weight = value;
            gnnf_pkg::CFG_RAD_WEIGHT: rad_weight = value;
            default: ;
        endcase
    endtask

    // Wait until every beat is taken and every fusion has come, then let the block settle
    task automatic wait_drained();
        do
            @(posedge clk);
        while (beats_taken != beats_queued || expected_fusions.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return COORD_MAX[COORD_W-1:0];
            1:       return COORD_MIN[COORD_W-1:0];
            2:       return COORD_W'(int'($urandom_range(0, 4000)) - 2000);
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] jitter(
        input logic signed [COORD_W-1:0] base,
        input int                        spread
    );
        int v;
        v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > COORD_MAX)
            v = COORD_MAX;
        else if (v < COORD_MIN)
            v = COORD_MIN;
        return v[COORD_W-1:0];
    endfunction

    // One frame: begin, a cluster of radar loads, camera tracks near them, a little noise
    task automatic queue_frame(input int n_radar, input int n_cam);
        logic signed [COORD_W-1:0] lx[$];
        logic signed [COORD_W-1:0] ly[$];
        logic signed [COORD_W-1:0] cx, cy, px, py;
        int spread, k, pick;
        spread = (gate_reg > 2000) ? 2000 : int'(gate_reg) + 16;
        cx = rand_coord();
        cy = rand_coord();
        send(gnnf_pkg::OP_BEGIN_FRAME, 16'($urandom), 16'($urandom), 16'($urandom));
        for (k = 0; k < n_radar; k++)
        begin
            px = jitter(cx, 3 * spread);
            py = jitter(cy, 3 * spread);
            lx = {lx, px};
            ly = {ly, py};
            send(gnnf_pkg::OP_LOAD_RADAR, 16'($urandom), px, py);
            if ($urandom_range(0, 15) == 0)
                send(gnnf_pkg::OP_RESERVED, 16'($urandom), 16'($urandom), 16'($urandom));
        end
        for (k = 0; k < n_cam; k++)
        begin
            pick = (lx.size() > 0) ? $urandom_range(0, lx.size() - 1) : 0;
            if (lx.size() == 0)
            begin
                px = jitter(cx, spread);
                py = jitter(cy, spread);
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:
                    begin
                        px = COORD_W'($urandom);
                        py = COORD_W'($urandom);
                    end
                    1:
                    begin
                        px = lx[pick];
                        py = ly[pick];
                    end
                    default:
                    begin
                        px = jitter(lx[pick], spread);
                        py = jitter(ly[pick], spread);
                    end
                endcase
            end
            send(gnnf_pkg::OP_CAMERA, 16'($urandom), px, py);
            // break the frame now and then
            case ($urandom_range(0, 24))
                0:       send(gnnf_pkg::OP_BEGIN_FRAME, 16'($urandom), 16'($urandom),
                              16'($urandom));
                1:       send(gnnf_pkg::OP_LOAD_RADAR, 16'($urandom), jitter(cx, spread),
                              jitter(cy, spread));
                2:       send(gnnf_pkg::OP_RESERVED, 16'($urandom), 16'($urandom),
                              16'($urandom));
                default: ;
            endcase
        end
    endtask

    task automatic run_phase(
        input logic [CFG_W-1:0] gate,
        input logic [CFG_W-1:0] cw,
        input logic [CFG_W-1:0] rw,
        input int               budget,
        input int               n_full,
        input bit               tx_on,
        input bit               rx_on
    );
        int k;
        write_register(gnnf_pkg::CFG_GATE, gate);
        write_register(gnnf_pkg::CFG_CAM_WEIGHT, cw);
        write_register(gnnf_pkg::CFG_RAD_WEIGHT, rw);
        tx_idle <= tx_on;
        rx_idle <= rx_on;
        phase_items = 0;
        for (k = 0; k < n_full; k++)
            queue_frame(MAX_RADAR + $urandom_range(1, 6), $urandom_range(3, 8));
        while (phase_items < budget)
            queue_frame($urandom_range(0, 7), $urandom_range(1, 8));
        wait_drained();
    endtask

    initial
    begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frame under reset settings
        send(gnnf_pkg::OP_CAMERA, 16'h0000, 16'sd0, 16'sd0);       // empty table, no match
        send(gnnf_pkg::OP_RESERVED, 16'hffff, 16'h7fff, 16'h8000); // ignored opcode
        send(gnnf_pkg::OP_BEGIN_FRAME, 16'hffff, 16'h8000, 16'h7fff);
        send(gnnf_pkg::OP_LOAD_RADAR, 16'h0000, 16'sd0, 16'sd0);
        send(gnnf_pkg::OP_LOAD_RADAR, 16'hffff, 16'h7fff, 16'h7fff);
        send(gnnf_pkg::OP_LOAD_RADAR, 16'h1234, 16'h8000, 16'h8000);
        send(gnnf_pkg::OP_LOAD_RADAR, 16'h0001, 16'sd100, 16'sd0);
        send(gnnf_pkg::OP_LOAD_RADAR, 16'h0002, -16'sd100, 16'sd0);
        send(gnnf_pkg::OP_LOAD_RADAR, 16'h0003, 16'sd0, 16'sd1700);
        send(gnnf_pkg::OP_CAMERA, 16'hffff, 16'sd0, 16'sd0);       // exact hit on entry 0
        send(gnnf_pkg::OP_CAMERA, 16'h0101, 16'sd0, 16'sd0);       // tie, lower index wins
        send(gnnf_pkg::OP_CAMERA, 16'h0202, 16'sd0, 16'sd0);       // tie partner left over
        send(gnnf_pkg::OP_CAMERA, 16'h0303, 16'sd0, 16'sd0);       // nearest left is outside
        send(gnnf_pkg::OP_CAMERA, 16'h0404, 16'sd0, 16'sd100);     // distance equals gate
        send(gnnf_pkg::OP_CAMERA, 16'h0505, 16'sd0, 16'sd101);     // just inside gate
        send(gnnf_pkg::OP_CAMERA, 16'h0606, 16'h7fff, 16'h7fff);
        send(gnnf_pkg::OP_CAMERA, 16'h0707, 16'h8000, 16'h8000);
        send(gnnf_pkg::OP_CAMERA, 16'h0808, 16'h8000, 16'h7fff);   // everything used or far
        wait_drained();

        // Random frames under reset settings, then a sweep of register settings
        tx_idle <= 1'b1;
        rx_idle <= 1'b1;
        phase_items = 0;
        while (phase_items < 130)
            queue_frame($urandom_range(0, 7), $urandom_range(1, 8));
        wait_drained();

        run_phase(16'd0, 16'd32768, 16'd0, 60, 0, 1'b1, 1'b1);
        run_phase(16'd65535, 16'd65535, 16'd65535, 130, 1, 1'b0, 1'b0);
        run_phase(16'd400, 16'd0, 16'd32768, 130, 0, 1'b1, 1'b0);
        run_phase(16'd3000, 16'd24576, 16'd8192, 130, 1, 1'b0, 1'b1);
        run_phase(16'($urandom_range(50, 5000)), 16'($urandom), 16'($urandom), 130, 0,
                  1'b1, 1'b1);

        // Back-pressure: receiver holds off while the sender keeps offering
        write_register(gnnf_pkg::CFG_GATE, 16'd2000);
        write_register(gnnf_pkg::CFG_CAM_WEIGHT, gnnf_pkg::CAM_WEIGHT_RESET);
        write_register(gnnf_pkg::CFG_RAD_WEIGHT, gnnf_pkg::RAD_WEIGHT_RESET);
        tx_idle <= 1'b0;
        rx_idle <= 1'b0;
        queue_frame(8, 12);
        @(posedge clk);
        hold_arm <= 1'b1;
        wait_drained();

        if (expected_fusions.size() != 0)
            report_mismatch($sformatf("%0d fusions never arrived", expected_fusions.size()));
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
